// File: hdl/sorted_interval_join_macros.svh
// Assertion macros used by the checker file of sorted_interval_join.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef SORTED_INTERVAL_JOIN_MACROS_SVH
`define SORTED_INTERVAL_JOIN_MACROS_SVH

// same-cycle implication
`define SIJ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SIJ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/sij_pkg.sv
// Shared types and constants of sorted_interval_join.
// Depends on nothing; the module files refer to it by scoped names.
package sij_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_QUERY,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } front_status_type;

   typedef struct packed {
      logic push;
      logic last;
   } rsp_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_SKIP,
      ST_EMIT,
      ST_FLUSH
   } eng_state_type;

endpackage

// File: hdl/sij_front.sv
// Front end of sorted_interval_join: takes request beats, decodes the command
// and holds decoded items in a two-entry queue for the engine. Uses sij_pkg.
module sij_front #(
   parameter int VALUE_WIDTH = sij_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_cmd,
   input  logic signed [VALUE_WIDTH-1:0] req_key,
   input  logic signed [VALUE_WIDTH-1:0] req_high_bound,
   output sij_pkg::front_status_type     fe,
   output logic signed [VALUE_WIDTH-1:0] fe_key,
   output logic signed [VALUE_WIDTH-1:0] fe_high,
   input  logic                          fe_pop
);

   sij_pkg::op_type             op_q   [2];
   logic signed [VALUE_WIDTH-1:0] key_q  [2];
   logic signed [VALUE_WIDTH-1:0] high_q [2];

   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   logic            accept;
   logic            cmd_ok;
   logic            enq;
   sij_pkg::op_type dec_op;

   always_comb begin
      cmd_ok = 1'b1;
      dec_op = sij_pkg::OP_LOAD;
      unique case (req_cmd)
         sij_pkg::CMD_LOAD:  dec_op = sij_pkg::OP_LOAD;
         sij_pkg::CMD_QUERY: dec_op = sij_pkg::OP_QUERY;
         sij_pkg::CMD_CLEAR: dec_op = sij_pkg::OP_CLEAR;
         default:            cmd_ok = 1'b0;
      endcase
   end

   assign req_full = (cnt_ff == 2'd2);
   assign accept   = req_push && !req_full;
   // drop beats with an unused command
   assign enq      = accept && cmd_ok;

   always_comb begin
      wr_ptr_in = enq    ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = fe_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, enq} - {1'b0, fe_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         op_q[wr_ptr_ff]   <= dec_op;
         key_q[wr_ptr_ff]  <= req_key;
         high_q[wr_ptr_ff] <= req_high_bound;
      end
   end

   assign fe.valid = (cnt_ff != 2'd0);
   assign fe.op    = op_q[rd_ptr_ff];
   assign fe_key   = key_q[rd_ptr_ff];
   assign fe_high  = high_q[rd_ptr_ff];

endmodule

// File: hdl/sij_engine.sv
// Back end of sorted_interval_join: interval table memory, scan pointer and
// the sequencer that walks the table for each query. Uses sij_pkg.
module sij_engine #(
   parameter int TABLE_DEPTH = sij_pkg::TABLE_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = sij_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sij_pkg::front_status_type     fe,
   input  logic signed [VALUE_WIDTH-1:0] fe_key,
   input  logic signed [VALUE_WIDTH-1:0] fe_high,
   output logic                          fe_pop,
   input  logic                          rsp_full,
   output sij_pkg::rsp_ctl_type          rsp_ctl,
   output logic signed [VALUE_WIDTH-1:0] rsp_key,
   output logic signed [VALUE_WIDTH-1:0] rsp_low,
   output logic signed [VALUE_WIDTH-1:0] rsp_high
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   logic signed [VALUE_WIDTH-1:0] low_mem  [TABLE_DEPTH];
   logic signed [VALUE_WIDTH-1:0] high_mem [TABLE_DEPTH];

   sij_pkg::eng_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic signed [VALUE_WIDTH-1:0] rd_low_ff, rd_high_ff;
   logic signed [VALUE_WIDTH-1:0] pend_low_ff, pend_high_ff;

   logic             mem_we;
   logic             rd_en;
   logic [CNT_W-1:0] rd_addr;
   logic             load_pend;
   logic [CNT_W-1:0] next_idx;
   logic             has_next;
   logic             key_lt_low;
   logic             key_gt_high;
   logic             in_range;
   logic             table_full;

   assign next_idx    = cur_ff + 1'b1;
   assign has_next    = (next_idx < count_ff);
   assign key_lt_low  = (key_ff < rd_low_ff);
   assign key_gt_high = (key_ff > rd_high_ff);
   assign in_range    = !key_lt_low && !key_gt_high;
   assign table_full  = (count_ff >= DEPTH_CNT);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sij_pkg::ST_IDLE: begin
            if (fe.valid && fe.op == sij_pkg::OP_QUERY && scan_ff < count_ff) begin
               state_in = sij_pkg::ST_FIRST;
            end
         end
         sij_pkg::ST_FIRST, sij_pkg::ST_SKIP: begin
            if (state_ff == sij_pkg::ST_FIRST && key_lt_low) begin
               state_in = sij_pkg::ST_IDLE;
            end else if (key_gt_high) begin
               state_in = has_next ? sij_pkg::ST_SKIP : sij_pkg::ST_IDLE;
            end else if (!key_lt_low) begin
               state_in = has_next ? sij_pkg::ST_EMIT : sij_pkg::ST_FLUSH;
            end else begin
               state_in = sij_pkg::ST_IDLE;
            end
         end
         sij_pkg::ST_EMIT: begin
            if (!rsp_full) begin
               if (in_range) begin
                  state_in = has_next ? sij_pkg::ST_EMIT : sij_pkg::ST_FLUSH;
               end else begin
                  state_in = sij_pkg::ST_IDLE;
               end
            end
         end
         sij_pkg::ST_FLUSH: begin
            if (!rsp_full) begin
               state_in = sij_pkg::ST_IDLE;
            end
         end
         default: state_in = sij_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      fe_pop       = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cur_ff;
      load_pend    = 1'b0;
      rsp_ctl.push = 1'b0;
      rsp_ctl.last = 1'b0;
      count_in     = count_ff;
      scan_in      = scan_ff;
      cur_in       = cur_ff;
      key_in       = key_ff;
      unique case (state_ff)
         sij_pkg::ST_IDLE: begin
            if (fe.valid) begin
               fe_pop = 1'b1;
               case (fe.op)
                  sij_pkg::OP_LOAD: begin
                     if (!table_full) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  sij_pkg::OP_CLEAR: begin
                     count_in = '0;
                     scan_in  = '0;
                  end
                  sij_pkg::OP_QUERY: begin
                     key_in = fe_key;
                     if (scan_ff < count_ff) begin
                        rd_en   = 1'b1;
                        rd_addr = scan_ff;
                        cur_in  = scan_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         sij_pkg::ST_FIRST, sij_pkg::ST_SKIP: begin
            if (state_ff == sij_pkg::ST_FIRST && key_lt_low) begin
               // key below the pointed interval: stop
            end else if (key_gt_high) begin
               scan_in = next_idx;
               if (has_next) begin
                  rd_en   = 1'b1;
                  rd_addr = next_idx;
                  cur_in  = next_idx;
               end
            end else if (!key_lt_low) begin
               load_pend = 1'b1;
               if (has_next) begin
                  rd_en   = 1'b1;
                  rd_addr = next_idx;
                  cur_in  = next_idx;
               end
            end
         end
         sij_pkg::ST_EMIT: begin
            if (!rsp_full) begin
               rsp_ctl.push = 1'b1;
               rsp_ctl.last = !in_range;
               if (in_range) begin
                  load_pend = 1'b1;
                  if (has_next) begin
                     rd_en   = 1'b1;
                     rd_addr = next_idx;
                     cur_in  = next_idx;
                  end
               end
            end
         end
         sij_pkg::ST_FLUSH: begin
            if (!rsp_full) begin
               rsp_ctl.push = 1'b1;
               rsp_ctl.last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sij_pkg::ST_IDLE;
         count_ff <= '0;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff  <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      key_ff <= key_in;
      if (load_pend) begin
         pend_low_ff  <= rd_low_ff;
         pend_high_ff <= rd_high_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         low_mem[count_ff[IDX_W-1:0]]  <= fe_key;
         high_mem[count_ff[IDX_W-1:0]] <= fe_high;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_low_ff  <= low_mem[rd_addr[IDX_W-1:0]];
         rd_high_ff <= high_mem[rd_addr[IDX_W-1:0]];
      end
   end

   assign rsp_key  = key_ff;
   assign rsp_low  = pend_low_ff;
   assign rsp_high = pend_high_ff;

endmodule

// File: hdl/sij_rsp_buf.sv
// Result queue of sorted_interval_join: two entries between the engine and
// the response port, so the engine keeps going while a beat waits. Uses sij_pkg.
module sij_rsp_buf #(
   parameter int VALUE_WIDTH = sij_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sij_pkg::rsp_ctl_type          ctl,
   input  logic signed [VALUE_WIDTH-1:0] in_key,
   input  logic signed [VALUE_WIDTH-1:0] in_low,
   input  logic signed [VALUE_WIDTH-1:0] in_high,
   output logic                          full,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [VALUE_WIDTH-1:0] rsp_matched_key,
   output logic signed [VALUE_WIDTH-1:0] rsp_matched_low,
   output logic signed [VALUE_WIDTH-1:0] rsp_matched_high,
   output logic                          rsp_last_match
);

   localparam int ENTRY_W = 3 * VALUE_WIDTH + 1;

   logic [ENTRY_W-1:0] entry_q [2];
   logic [ENTRY_W-1:0] head;

   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       enq;
   logic       deq;

   assign full      = (cnt_ff == 2'd2);
   assign rsp_empty = (cnt_ff == 2'd0);
   assign enq       = ctl.push && !full;
   assign deq       = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = enq ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deq ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, enq} - {1'b0, deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         entry_q[wr_ptr_ff] <= {in_key, in_low, in_high, ctl.last};
      end
   end

   assign head             = entry_q[rd_ptr_ff];
   assign rsp_matched_key  = head[ENTRY_W-1 -: VALUE_WIDTH];
   assign rsp_matched_low  = head[2*VALUE_WIDTH -: VALUE_WIDTH];
   assign rsp_matched_high = head[VALUE_WIDTH -: VALUE_WIDTH];
   assign rsp_last_match   = head[0];

endmodule

// File: hdl/sorted_interval_join.sv
// sorted_interval_join: joins an ascending key stream against a stored,
// sorted list of closed intervals.
//
// Request side is a queue port: a beat is taken when req_push is high and
// req_full is low. req_cmd selects load (append [req_key, req_high_bound]),
// query (req_key), or clear (empty the table, rewind the scan pointer);
// the unused code is taken and dropped. Loads into a full table are dropped.
// Result side is a queue port: the oldest result sits on rsp_* while
// rsp_empty is low and leaves when rsp_pop is high. Each query gives one
// beat per matching interval, the final one with rsp_last_match set, or
// none. A two-entry request queue and a two-entry result queue decouple the
// ports from the table sequencer.
// The sequencer walks the table for a query, skipping intervals that lie
// below the key and then reading the matches; its pace is set by the single
// read port of the table memory, one entry per cycle while the result queue
// has room. When the receiver stalls the sequencer holds once the result
// queue fills, then the request queue fills and req_full rises. Reset
// empties both queues, the table and the scan pointer; no clearing pass is
// needed.
module sorted_interval_join #(
   parameter int TABLE_DEPTH = sij_pkg::TABLE_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = sij_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_cmd,
   input  logic signed [VALUE_WIDTH-1:0] req_key,
   input  logic signed [VALUE_WIDTH-1:0] req_high_bound,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [VALUE_WIDTH-1:0] rsp_matched_key,
   output logic signed [VALUE_WIDTH-1:0] rsp_matched_low,
   output logic signed [VALUE_WIDTH-1:0] rsp_matched_high,
   output logic                          rsp_last_match
);

   sij_pkg::front_status_type     fe;
   logic signed [VALUE_WIDTH-1:0] fe_key;
   logic signed [VALUE_WIDTH-1:0] fe_high;
   logic                          fe_pop;
   sij_pkg::rsp_ctl_type          eng_ctl;
   logic signed [VALUE_WIDTH-1:0] eng_key;
   logic signed [VALUE_WIDTH-1:0] eng_low;
   logic signed [VALUE_WIDTH-1:0] eng_high;
   logic                          buf_full;

   sij_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .req_high_bound (req_high_bound),
      .fe             (fe),
      .fe_key         (fe_key),
      .fe_high        (fe_high),
      .fe_pop         (fe_pop)
   );

   sij_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .fe       (fe),
      .fe_key   (fe_key),
      .fe_high  (fe_high),
      .fe_pop   (fe_pop),
      .rsp_full (buf_full),
      .rsp_ctl  (eng_ctl),
      .rsp_key  (eng_key),
      .rsp_low  (eng_low),
      .rsp_high (eng_high)
   );

   sij_rsp_buf #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_rsp_buf (
      .clock            (clock),
      .reset            (reset),
      .ctl              (eng_ctl),
      .in_key           (eng_key),
      .in_low           (eng_low),
      .in_high          (eng_high),
      .full             (buf_full),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_matched_key  (rsp_matched_key),
      .rsp_matched_low  (rsp_matched_low),
      .rsp_matched_high (rsp_matched_high),
      .rsp_last_match   (rsp_last_match)
   );

endmodule

// File: hdl/sij_port_checker.sv
// Port-level checker of sorted_interval_join, bound to the top level below.
// Depends on sij_pkg and sorted_interval_join_macros.svh.
`include "sorted_interval_join_macros.svh"

module sij_port_checker #(
   parameter int VALUE_WIDTH = sij_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_push,
   input logic                          req_full,
   input logic [1:0]                    req_cmd,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic signed [VALUE_WIDTH-1:0] rsp_matched_key,
   input logic signed [VALUE_WIDTH-1:0] rsp_matched_low,
   input logic signed [VALUE_WIDTH-1:0] rsp_matched_high,
   input logic                          rsp_last_match
);

   logic                          seen_query_ff;
   logic                          expect_ff;
   logic signed [VALUE_WIDTH-1:0] cont_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_query_ff <= 1'b0;
         expect_ff     <= 1'b0;
      end else begin
         if (req_push && !req_full && req_cmd == sij_pkg::CMD_QUERY) begin
            seen_query_ff <= 1'b1;
         end
         if (rsp_pop && !rsp_empty) begin
            expect_ff <= !rsp_last_match;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_pop && !rsp_empty) begin
         cont_key_ff <= rsp_matched_key;
      end
   end

   `SIJ_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty, "results after reset")
   `SIJ_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_matched_key) && $stable(rsp_last_match), "waiting beat changed")
   `SIJ_ASSERT_NOW(a_in_bounds, clock, reset, !rsp_empty, rsp_matched_low <= rsp_matched_key && rsp_matched_key <= rsp_matched_high, "key outside interval")
   `SIJ_ASSERT_NOW(a_same_key, clock, reset, !rsp_empty && expect_ff, rsp_matched_key == cont_key_ff, "match group key changed")
   `SIJ_ASSERT_NOW(a_query_first, clock, reset, !rsp_empty, seen_query_ff, "result without a query")

endmodule

bind sorted_interval_join sij_port_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_port_checker (
   .clock            (clock),
   .reset            (reset),
   .req_push         (req_push),
   .req_full         (req_full),
   .req_cmd          (req_cmd),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_matched_key  (rsp_matched_key),
   .rsp_matched_low  (rsp_matched_low),
   .rsp_matched_high (rsp_matched_high),
   .rsp_last_match   (rsp_last_match)
);
